// File: rtl/fdt_pkg.sv
// Shared types and constants for the 16.16 fixed-point to decimal text converter.
// Holds the controller state enum, the command and status structs, and ASCII codes.
// No dependencies.
package fdt_pkg;

  localparam logic [7:0]  ASCII_MINUS        = 8'd45;
  localparam logic [7:0]  ASCII_ZERO         = 8'd48;
  localparam logic [7:0]  DECIMAL_POINT_RST  = 8'd46;
  localparam logic [4:0]  DEFAULT_FRAC_DIGITS = 5'd4;
  // x / 10 == (x * 0xCCCD) >> 19 holds exactly for every 16-bit x.
  localparam logic [15:0] DIV10_RECIP        = 16'hCCCD;
  localparam int          DIV10_SHIFT        = 19;
  localparam logic [2:0]  MAX_INT_DIGITS     = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_INT,
    ST_POINT,
    ST_FRAC
  } fdt_state_t;

  typedef struct packed {
    logic load;
    logic conv_step;
    logic emit_sign;
    logic emit_int;
    logic emit_point;
    logic emit_frac;
  } fdt_cmd_t;

  typedef struct packed {
    logic is_neg;
    logic conv_done;
    logic int_last;
    logic frac_none;
    logic frac_last;
    logic out_free;
  } fdt_status_t;

endpackage

// File: rtl/fdt_ctrl.sv
// Controller state machine for the fixed-point to decimal text converter.
// Sequences load, integer digit conversion and character emission.
// Depends on fdt_pkg.
module fdt_ctrl
  import fdt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  fdt_status_t sts,
  output fdt_cmd_t    cmd
);

  fdt_state_t state_r;
  fdt_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_CONV;
      end
      ST_CONV: begin
        if (sts.conv_done) state_nxt = sts.is_neg ? ST_SIGN : ST_INT;
      end
      ST_SIGN: begin
        if (sts.out_free) state_nxt = ST_INT;
      end
      ST_INT: begin
        if (sts.out_free && sts.int_last) begin
          state_nxt = sts.frac_none ? ST_IDLE : ST_POINT;
        end
      end
      ST_POINT: begin
        if (sts.out_free) state_nxt = ST_FRAC;
      end
      ST_FRAC: begin
        if (sts.out_free && sts.frac_last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_CONV:  cmd.conv_step  = 1'b1;
      ST_SIGN:  cmd.emit_sign  = sts.out_free;
      ST_INT:   cmd.emit_int   = sts.out_free;
      ST_POINT: cmd.emit_point = sts.out_free;
      ST_FRAC:  cmd.emit_frac  = sts.out_free;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// File: rtl/fdt_dp.sv
// Datapath for the fixed-point to decimal text converter: operand registers,
// divide-by-ten digit extraction, fraction times-ten step and the output register.
// Depends on fdt_pkg.
module fdt_dp
  import fdt_pkg::*;
#(
  parameter int MAX_FRACTION_DIGITS = 15,
  parameter int FW = 4
)
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic signed [31:0] in_value,
  input  logic signed [4:0]  in_digit_count,
  input  logic               cfg_wr_en,
  input  logic [7:0]         cfg_wr_data,
  input  fdt_cmd_t           cmd,
  output fdt_status_t        sts,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [7:0]         out_text_char,
  output logic               out_last
);

  logic [7:0]    dec_point_r;
  logic          neg_r;
  logic [15:0]   ip_r;
  logic [15:0]   fb_r;
  logic [FW-1:0] left_r;
  logic [2:0]    icnt_r;
  logic [3:0]    digits_r [MAX_INT_DIGITS];
  logic          out_valid_r;
  logic [7:0]    out_char_r;
  logic          out_last_r;

  logic [31:0]   mag;
  logic [4:0]    cnt_sel;
  logic [FW-1:0] cnt_sat;
  logic [31:0]   div_prod;
  logic [15:0]   quot;
  logic [15:0]   rem_full;
  logic [19:0]   frac_x10;
  logic [2:0]    rd_idx;
  logic          emit_any;

  // Load-time decomposition into sign, integer magnitude and fraction bits.
  assign mag     = in_value[31] ? (32'd0 - 32'(in_value)) : 32'(in_value);
  assign cnt_sel = in_digit_count[4] ? DEFAULT_FRAC_DIGITS : 5'(in_digit_count);
  assign cnt_sat = (32'(cnt_sel) > 32'(MAX_FRACTION_DIGITS)) ?
                   FW'(MAX_FRACTION_DIGITS) : FW'(cnt_sel);

  // Divide by ten through a reciprocal multiply; remainder by shift and add.
  assign div_prod = ip_r * DIV10_RECIP;
  assign quot     = 16'(div_prod >> DIV10_SHIFT);
  assign rem_full = ip_r - ({quot[12:0], 3'b000} + {quot[14:0], 1'b0});

  // Next fraction digit is the carry out of bit 15 after multiplying by ten.
  assign frac_x10 = {1'b0, fb_r, 3'b000} + {3'b000, fb_r, 1'b0};

  assign rd_idx   = icnt_r - 3'd1;
  assign emit_any = cmd.emit_sign | cmd.emit_int | cmd.emit_point | cmd.emit_frac;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_point_r <= DECIMAL_POINT_RST;
    end else if (cfg_wr_en) begin
      dec_point_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      neg_r  <= 1'b0;
      ip_r   <= '0;
      fb_r   <= '0;
      left_r <= '0;
      icnt_r <= '0;
    end else begin
      if (cmd.load) begin
        neg_r  <= in_value[31];
        ip_r   <= mag[31:16];
        fb_r   <= mag[15:0];
        left_r <= cnt_sat;
        icnt_r <= '0;
      end
      if (cmd.conv_step) begin
        ip_r   <= quot;
        icnt_r <= icnt_r + 3'd1;
      end
      if (cmd.emit_int) begin
        icnt_r <= rd_idx;
      end
      if (cmd.emit_frac) begin
        fb_r   <= frac_x10[15:0];
        left_r <= left_r - FW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.conv_step) begin
      digits_r[icnt_r] <= rem_full[3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_any) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_any) begin
      priority if (cmd.emit_sign) begin
        out_char_r <= ASCII_MINUS;
        out_last_r <= 1'b0;
      end else if (cmd.emit_int) begin
        out_char_r <= ASCII_ZERO + {4'd0, digits_r[rd_idx]};
        out_last_r <= (icnt_r == 3'd1) && (left_r == '0);
      end else if (cmd.emit_point) begin
        out_char_r <= dec_point_r;
        out_last_r <= 1'b0;
      end else begin
        out_char_r <= ASCII_ZERO + {4'd0, frac_x10[19:16]};
        out_last_r <= (left_r == FW'(1));
      end
    end
  end

  always_comb begin
    sts.is_neg    = neg_r;
    sts.conv_done = (quot == 16'd0) || (icnt_r == (MAX_INT_DIGITS - 3'd1));
    sts.int_last  = (icnt_r == 3'd1);
    sts.frac_none = (left_r == '0);
    sts.frac_last = (left_r == FW'(1));
    sts.out_free  = !out_valid_r || out_ready;
  end

  assign out_valid     = out_valid_r;
  assign out_text_char = out_char_r;
  assign out_last      = out_last_r;

  a_icnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    icnt_r <= MAX_INT_DIGITS)
    else $error("integer digit count out of range");

  a_frac_left: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_frac |-> left_r != '0)
    else $error("fraction digit emitted with none left");

  a_int_idx: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_int |-> (icnt_r != 3'd0) && (digits_r[rd_idx] <= 4'd9))
    else $error("integer digit read out of range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    emit_any |-> (!out_valid_r || out_ready))
    else $error("output register overwritten while held");

endmodule

// File: rtl/fixed16_16_to_decimal_text.sv
// Top level of the signed 16.16 fixed-point to decimal ASCII text converter.
// Instantiates the controller fdt_ctrl and the datapath fdt_dp; depends on fdt_pkg.
//
// Input channel (in_valid/in_ready): one transfer carries a signed 16.16 value and a
// signed fraction digit count (negative selects four, larger counts are limited to
// MAX_FRACTION_DIGITS). Output channel (out_valid/out_ready): each transfer is one ASCII
// character; out_last marks the final character of a value's text. The text is an
// optional '-', the integer digits without leading zeros, then, for a nonzero count, the
// decimal point and the truncated fraction digits. cfg_wr_en/cfg_wr_data write the
// decimal point character (reset value is a period); write it only while idle.
// Timing: one item at a time. After an input transfer the divide-by-ten unit extracts the
// integer digits (1 to 5), then the block emits one character per cycle into the output
// register while the receiver takes them. in_ready is high again in the cycle in which
// the last character sits in the output register, so the next item is taken while that
// character still waits.
// Reset (synchronous, active low) returns the controller to idle, empties the output
// register and restores the period as decimal point. A stalled receiver holds the output
// register; emission pauses until it is taken, and no character is dropped or repeated.
module fixed16_16_to_decimal_text
  import fdt_pkg::*;
#(
  parameter int MAX_FRACTION_DIGITS = 15
)
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_value,
  input  logic signed [4:0]  in_digit_count,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_text_char,
  output logic               out_last,
  input  logic               cfg_wr_en,
  input  logic [7:0]         cfg_wr_data
);

  // Width of the fraction digit counter follows from the largest count.
  localparam int FW = $clog2(MAX_FRACTION_DIGITS + 1);

  fdt_cmd_t    cmd;
  fdt_status_t sts;

  // The controller decides what happens each cycle; the datapath does it.
  fdt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fdt_dp #(
    .MAX_FRACTION_DIGITS (MAX_FRACTION_DIGITS),
    .FW                  (FW)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_value       (in_value),
    .in_digit_count (in_digit_count),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .cmd            (cmd),
    .sts            (sts),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_text_char  (out_text_char),
    .out_last       (out_last)
  );

endmodule
